@@ hdl/cbps_pkg.sv @@
// Shared constants, types and helpers of the credit burst port scheduler.
package cbps_pkg;

	// Table geometry.
	localparam int PORTS       = 8;
	localparam int CREDIT_BITS = 8;
	localparam int PIDX_W      = $clog2(PORTS);

	// Field widths fixed by the word formats.
	localparam int CREDIT_W    = 64;
	localparam int VALUE_W     = 64;
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = 58;
	localparam int REM_W       = 26;
	localparam int TAG_W       = 32;
	localparam int DEST_W      = 14;
	localparam int COOKIE_W    = 8;
	localparam int BLOCK_SHIFT = 6;
	localparam int TAG_STEP_SH = 3;

	// Configuration register map (register index taken from paddr[2]).
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic [CNT_W-1:0] THRESHOLD_RESET = 7'd8;

	// Kind of an input word.
	typedef enum logic {
		KIND_SETTING  = 1'b0,
		KIND_SCHEDULE = 1'b1
	} kind_t;

	// Setting selectors of a setting write.
	typedef enum logic [2:0] {
		SET_COOKIE      = 3'd0,
		SET_REPLY_DEST  = 3'd1,
		SET_BASE        = 3'd2,
		SET_LENGTH      = 3'd3,
		SET_FIRST_TAG   = 3'd4,
		SET_LAST_TAG    = 3'd5,
		SET_DATA_DEST   = 3'd6,
		SET_INVALID     = 3'd7
	} setting_tag_t;

	// Input word.
	typedef struct packed {
		logic                kind;
		logic [2:0]          port;
		logic [2:0]          setting_tag;
		logic [VALUE_W-1:0]  setting_value;
		logic [CREDIT_W-1:0] credits;
	} item_t;

	// Result word.
	typedef struct packed {
		logic                granted;
		logic [2:0]          granted_port;
		logic [CNT_W-1:0]    block_count;
		logic [ADDR_W-1:0]   block_address;
		logic [TAG_W-1:0]    first_tag;
		logic [TAG_W-1:0]    end_tag;
		logic [DEST_W-1:0]   data_dest;
		logic [DEST_W-1:0]   reply_dest;
		logic [COOKIE_W-1:0] reply_cookie;
		logic                finishes;
		logic                bad_setting;
	} result_t;

	// What one lane finds for its port.
	typedef struct packed {
		logic             qual;
		logic [CNT_W-1:0] count;
		logic             finish;
	} lane_res_t;

	// What the merge stage picks.
	typedef struct packed {
		logic              found;
		logic [PIDX_W-1:0] port;
		logic [CNT_W-1:0]  count;
		logic              finish;
	} pick_t;

	// Halved credit of port p; counters above the packed word read as zero.
	function automatic logic [CNT_W-1:0] credit_of(input logic [CREDIT_W-1:0] credits,
		input int p);
		logic [CREDIT_W-1:0]    sh;
		logic [CREDIT_BITS-1:0] ctr;
		sh  = (p * CREDIT_BITS >= CREDIT_W) ? '0 : (credits >> (p * CREDIT_BITS));
		ctr = sh[CREDIT_BITS-1:0];
		return CNT_W'(ctr >> 1);
	endfunction

endpackage

@@ hdl/cbps_lane.sv @@
// One scheduling lane: qualifies a single port and sizes its burst.
module cbps_lane (
	input  logic                           active,
	input  logic [cbps_pkg::REM_W-1:0]     remaining,
	input  logic [cbps_pkg::CNT_W-1:0]     avail,
	input  logic [cbps_pkg::CNT_W-1:0]     threshold,
	output cbps_pkg::lane_res_t            res
);
	import cbps_pkg::*;

	logic short_len;

	// The burst is the smaller of the remaining length and the credit.
	always_comb begin
		short_len  = remaining < REM_W'(avail);
		res.qual   = active && (remaining != '0) && (avail >= threshold);
		res.finish = short_len;
		res.count  = short_len ? remaining[CNT_W-1:0] : avail;
	end

endmodule

@@ hdl/cbps_merge.sv @@
// Merge stage: the highest-numbered qualifying lane wins the grant.
module cbps_merge (
	input  cbps_pkg::lane_res_t lanes [cbps_pkg::PORTS],
	output cbps_pkg::pick_t     pick
);
	import cbps_pkg::*;

	// Priority scan; later lanes override earlier ones.
	always_comb begin
		pick = '0;
		for (int p = 0; p < PORTS; p++) begin
			if (lanes[p].qual) begin
				pick.found  = 1'b1;
				pick.port   = PIDX_W'(p);
				pick.count  = lanes[p].count;
				pick.finish = lanes[p].finish;
			end
		end
	end

endmodule

@@ hdl/credit_burst_port_scheduler.sv @@
// Top level of the credit burst port scheduler: settings table, lanes and result register.
//
//   channel   signals                                  transfer
//   input     start, busy, item                        start high while busy is low
//   result    done, result                             done high for one cycle
//   config    psel, penable, pwrite, paddr, pwdata,    access phase, pready always high
//             prdata, pready
//
// Every word is captured at the accepting edge, the lanes and the merge stage evaluate
// the table and the table is updated at the next edge, and the result is shown with
// done in the cycle after. The single table read-modify-write keeps one word at work at
// a time; busy is high only in the cycle between. Reset clears the whole table and loads
// the threshold with its default. The result side cannot stall.
module credit_burst_port_scheduler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cbps_pkg::item_t   item,
	output logic              done,
	output cbps_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cbps_pkg::*;

	// Settings table.
	logic                active_q    [PORTS];
	logic [COOKIE_W-1:0] cookie_q    [PORTS];
	logic [DEST_W-1:0]   reply_dest_q[PORTS];
	logic [ADDR_W-1:0]   base_q      [PORTS];
	logic [REM_W-1:0]    remaining_q [PORTS];
	logic [TAG_W-1:0]    next_tag_q  [PORTS];
	logic [TAG_W-1:0]    end_tag_q   [PORTS];
	logic [DEST_W-1:0]   data_dest_q [PORTS];

	logic [CNT_W-1:0]    thr_q;
	item_t               item_s1;
	logic                valid_s1;
	logic                done_q;
	result_t             result_q;
	result_t             res_d;

	lane_res_t           lanes[PORTS];
	pick_t               pick;
	logic                cfg_wr;
	logic                set_wr;
	logic                in_range;
	logic [PIDX_W-1:0]   set_idx;

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;

	// Configuration port.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
			thr_q <= pwdata[CNT_W-1:0];
		end
	end

	// Capture stage for the accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !valid_s1) begin
			item_s1 <= item;
		end
	end

	// One lane per port.
	for (genvar p = 0; p < PORTS; p++) begin : g_lane
		cbps_lane u_lane (
			.active   (active_q[p]),
			.remaining(remaining_q[p]),
			.avail    (credit_of(item_s1.credits, p)),
			.threshold(thr_q),
			.res      (lanes[p])
		);
	end

	cbps_merge u_merge (
		.lanes(lanes),
		.pick (pick)
	);

	// Result word for the word in the capture stage.
	always_comb begin
		res_d = '0;
		if (item_s1.kind == KIND_SETTING) begin
			res_d.bad_setting = (item_s1.setting_tag == SET_INVALID);
		end else if (pick.found) begin
			res_d.granted       = 1'b1;
			res_d.granted_port  = 3'(pick.port);
			res_d.block_count   = pick.count;
			res_d.block_address = base_q[pick.port];
			res_d.first_tag     = next_tag_q[pick.port];
			res_d.end_tag       = end_tag_q[pick.port];
			res_d.data_dest     = data_dest_q[pick.port];
			res_d.reply_dest    = reply_dest_q[pick.port];
			res_d.reply_cookie  = cookie_q[pick.port];
			res_d.finishes      = pick.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	// Table update: setting writes and grants.
	assign set_wr   = valid_s1 && (item_s1.kind == KIND_SETTING);
	assign in_range = 32'(item_s1.port) < PORTS;
	assign set_idx  = PIDX_W'(item_s1.port);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				active_q[p]     <= 1'b0;
				cookie_q[p]     <= '0;
				reply_dest_q[p] <= '0;
				base_q[p]       <= '0;
				remaining_q[p]  <= '0;
				next_tag_q[p]   <= '0;
				end_tag_q[p]    <= '0;
				data_dest_q[p]  <= '0;
			end
		end else if (set_wr && in_range) begin
			case (item_s1.setting_tag)
				SET_COOKIE: begin
					cookie_q[set_idx] <= item_s1.setting_value[COOKIE_W-1:0];
					active_q[set_idx] <= 1'b1;
				end
				SET_REPLY_DEST: begin
					reply_dest_q[set_idx] <= item_s1.setting_value[DEST_W-1:0];
				end
				SET_BASE: begin
					base_q[set_idx] <= item_s1.setting_value[BLOCK_SHIFT +: ADDR_W];
				end
				SET_LENGTH: begin
					remaining_q[set_idx] <= item_s1.setting_value[BLOCK_SHIFT +: REM_W];
				end
				SET_FIRST_TAG: begin
					next_tag_q[set_idx] <= item_s1.setting_value[TAG_W-1:0];
				end
				SET_LAST_TAG: begin
					end_tag_q[set_idx] <= item_s1.setting_value[TAG_W-1:0];
				end
				SET_DATA_DEST: begin
					data_dest_q[set_idx] <= item_s1.setting_value[DEST_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (valid_s1 && item_s1.kind == KIND_SCHEDULE && pick.found) begin
			if (pick.finish) begin
				active_q[pick.port] <= 1'b0;
			end
			remaining_q[pick.port] <= remaining_q[pick.port] - REM_W'(pick.count);
			base_q[pick.port]      <= base_q[pick.port] + ADDR_W'(pick.count);
			next_tag_q[pick.port]  <= next_tag_q[pick.port]
				+ TAG_W'({pick.count, {TAG_STEP_SH{1'b0}}});
		end
	end

	// Checks on the sequencing of words and results.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not enter the capture stage");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("captured word did not produce exactly one result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a word is still at work");

	// A zero threshold lets a port with zero credit win an empty burst.
	a_grant_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.granted |-> !result.bad_setting)
		else $error("grant result carries a setting flag");

endmodule
